FILE: hw/rtl/cde_pkg.sv
// ----------------------------------------------------------------------------
// Crystal deadtime efficiency package
// Shared constants, codes and types for the deadtime efficiency pipeline.
// ----------------------------------------------------------------------------
package cde_pkg;

  localparam int MAX_RINGS_DEF       = 32;
  localparam int MAX_BLOCK_WIDTH_DEF = 8;
  localparam int MAX_BUCKETS_DEF     = 64;

  // ln(2) in Q32.
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

  localparam int TAYLOR_TERMS = 12;
  localparam int RECIP_SHIFT  = 36;

  typedef enum logic [1:0] {
    ACT_LOAD_RING   = 2'd0,
    ACT_LOAD_TRANS  = 2'd1,
    ACT_LOAD_BUCKET = 2'd2,
    ACT_COMPUTE     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    CFG_CRYSTALS_IN_RING     = 3'd0,
    CFG_TRANSAXIAL_PER_BLOCK = 3'd1,
    CFG_AXIAL_PER_BLOCK      = 3'd2,
    CFG_BLOCKS_IN_BUCKET     = 3'd3,
    CFG_CRYSTALS_IN_BUCKET   = 3'd4,
    CFG_BUCKETS_IN_RING      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [9:0] crystals_in_ring;
    logic [3:0] transaxial_per_block;
    logic [5:0] axial_per_block;
    logic [3:0] blocks_in_bucket;
    logic [6:0] crystals_in_bucket;
    logic [6:0] buckets_in_ring;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    crystals_in_ring:     10'd384,
    transaxial_per_block: 4'd8,
    axial_per_block:      6'd8,
    blocks_in_bucket:     4'd3,
    crystals_in_bucket:   7'd24,
    buckets_in_ring:      7'd16
  };

endpackage

FILE: hw/rtl/cde_if.sv
// ----------------------------------------------------------------------------
// Crystal deadtime efficiency channels
// Valid/ready interfaces for the input word and the result word.
// ----------------------------------------------------------------------------
interface cde_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [5:0]  table_index;
  logic [4:0]  ring;
  logic [9:0]  crystal;
  logic [31:0] paralyzing_time;
  logic [31:0] nonparalyzing_time;
  logic [31:0] singles_rate;
  logic [31:0] base_efficiency;

  modport source (
    output valid, action, table_index, ring, crystal, paralyzing_time,
           nonparalyzing_time, singles_rate, base_efficiency,
    input  ready
  );
  modport sink (
    input  valid, action, table_index, ring, crystal, paralyzing_time,
           nonparalyzing_time, singles_rate, base_efficiency,
    output ready
  );
endinterface

interface cde_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] corrected_efficiency;
  logic [14:0] crystal_number;
  logic        saturated;

  modport source (
    output valid, corrected_efficiency, crystal_number, saturated,
    input  ready
  );
  modport sink (
    input  valid, corrected_efficiency, crystal_number, saturated,
    output ready
  );
endinterface

FILE: hw/rtl/cde_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage. The upper numerator bits above the quotient
// must be smaller than the divisor.
// ----------------------------------------------------------------------------
module cde_div import cde_pkg::*; #(
  parameter int NW = 16,
  parameter int DW = 8,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_in,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          v_out,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [SW-1:0] side_out
);

  logic          v_r    [QW];
  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] low_r  [QW];
  logic [QW-1:0] q_r    [QW];
  logic [DW-1:0] den_r  [QW];
  logic [SW-1:0] side_r [QW];

  logic [DW-1:0] rem_init;

  assign rem_init = DW'({{DW{1'b0}}, num} >> QW);

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic          v_src;
    logic [DW-1:0] rem_src;
    logic [QW-1:0] low_src;
    logic [QW-1:0] q_src;
    logic [DW-1:0] den_src;
    logic [SW-1:0] side_src;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (j == 0) begin : g_first
      assign v_src    = v_in;
      assign rem_src  = rem_init;
      assign low_src  = num[QW-1:0];
      assign q_src    = '0;
      assign den_src  = den;
      assign side_src = side_in;
    end else begin : g_next
      assign v_src    = v_r[j-1];
      assign rem_src  = rem_r[j-1];
      assign low_src  = low_r[j-1];
      assign q_src    = q_r[j-1];
      assign den_src  = den_r[j-1];
      assign side_src = side_r[j-1];
    end

    assign trial = {rem_src, low_src[QW-1]};
    assign diff  = trial - {1'b0, den_src};
    assign ge    = (trial >= {1'b0, den_src});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j]    <= v_src;
        rem_r[j]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        low_r[j]  <= QW'({low_src, 1'b0});
        q_r[j]    <= QW'({q_src, ge});
        den_r[j]  <= den_src;
        side_r[j] <= side_src;
      end
    end
  end

  assign v_out    = v_r[QW-1];
  assign quo      = q_r[QW-1];
  assign rem      = rem_r[QW-1];
  assign side_out = side_r[QW-1];

endmodule

FILE: hw/rtl/cde_exp.sv
// ----------------------------------------------------------------------------
// Pipelined exponential
// Taylor sum of exp(f) in Q32, two stages per term and one final add.
// ----------------------------------------------------------------------------
module cde_exp import cde_pkg::*; #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_in,
  input  logic [31:0]   f_in,
  input  logic [SW-1:0] side_in,
  output logic          v_out,
  output logic [33:0]   sum_out,
  output logic [SW-1:0] side_out
);

  localparam int NT = TAYLOR_TERMS;

  logic          a_v_r    [NT];
  logic [64:0]   a_prod_r [NT];
  logic [31:0]   a_f_r    [NT];
  logic [33:0]   a_sum_r  [NT];
  logic [SW-1:0] a_side_r [NT];

  logic          b_v_r    [NT];
  logic [69:0]   b_qm_r   [NT];
  logic [31:0]   b_f_r    [NT];
  logic [33:0]   b_sum_r  [NT];
  logic [SW-1:0] b_side_r [NT];

  logic          fin_v_r;
  logic [33:0]   fin_sum_r;
  logic [SW-1:0] fin_side_r;
  logic [32:0]   last_term;

  for (genvar i = 0; i < NT; i++) begin : g_term
    localparam int Nterm = i + 1;
    localparam logic [36:0] Recip = 37'(((64'd1 << RECIP_SHIFT) + Nterm - 1) / Nterm);

    logic          v_src;
    logic [32:0]   term_src;
    logic [31:0]   f_src;
    logic [33:0]   sum_src;
    logic [SW-1:0] side_src;
    logic [32:0]   prod_hi;

    if (i == 0) begin : g_first
      assign v_src    = v_in;
      assign term_src = 33'h1_0000_0000;
      assign f_src    = f_in;
      assign sum_src  = 34'h1_0000_0000;
      assign side_src = side_in;
    end else begin : g_next
      assign v_src    = b_v_r[i-1];
      assign term_src = b_qm_r[i-1][RECIP_SHIFT+32:RECIP_SHIFT];
      assign f_src    = b_f_r[i-1];
      assign sum_src  = b_sum_r[i-1] + {1'b0, term_src};
      assign side_src = b_side_r[i-1];
    end

    assign prod_hi = a_prod_r[i][64:32];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_v_r[i] <= 1'b0;
        b_v_r[i] <= 1'b0;
      end else if (en) begin
        a_v_r[i]    <= v_src;
        a_prod_r[i] <= {32'd0, term_src} * {33'd0, f_src};
        a_f_r[i]    <= f_src;
        a_sum_r[i]  <= sum_src;
        a_side_r[i] <= side_src;
        b_v_r[i]    <= a_v_r[i];
        b_qm_r[i]   <= {37'd0, prod_hi} * {33'd0, Recip};
        b_f_r[i]    <= a_f_r[i];
        b_sum_r[i]  <= a_sum_r[i];
        b_side_r[i] <= a_side_r[i];
      end
    end
  end

  assign last_term = b_qm_r[NT-1][RECIP_SHIFT+32:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r    <= b_v_r[NT-1];
      fin_sum_r  <= b_sum_r[NT-1] + {1'b0, last_term};
      fin_side_r <= b_side_r[NT-1];
    end
  end

  assign v_out    = fin_v_r;
  assign sum_out  = fin_sum_r;
  assign side_out = fin_side_r;

endmodule

FILE: hw/rtl/crystal_deadtime_efficiency.sv
// ----------------------------------------------------------------------------
// Crystal deadtime efficiency
// Deadtime-corrected crystal efficiency with table loads and a long
// fixed-point pipeline of dividers and an exponential.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake        Payload
//  in_ch    in         valid/ready      action, index, ring, crystal, times,
//                                       singles, base efficiency
//  out_ch   out        valid/ready      efficiency, crystal number, saturated
//  cfg_*    in         write enable     register index, data
//
//  One word is accepted per cycle while the skid register is empty.
//  The pipeline is mostly dividers, which settle one quotient bit per stage.
//  Reset is synchronous and clears valid bits and configuration registers.
//  A stalled output fills a skid register, and the whole pipeline holds
//  until the skid drains; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module crystal_deadtime_efficiency import cde_pkg::*; #(
  parameter int MAX_RINGS       = MAX_RINGS_DEF,
  parameter int MAX_BLOCK_WIDTH = MAX_BLOCK_WIDTH_DEF,
  parameter int MAX_BUCKETS     = MAX_BUCKETS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_data,
  cde_in_if.sink     in_ch,
  cde_out_if.source  out_ch
);

  localparam int RAW = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
  localparam int TAW = (MAX_BLOCK_WIDTH > 1) ? $clog2(MAX_BLOCK_WIDTH) : 1;
  localparam int BAW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

  typedef struct packed {
    action_t     action;
    logic [5:0]  idx;
    logic [4:0]  ring;
    logic [9:0]  crystal;
    logic [31:0] pt;
    logic [31:0] nt;
    logic [31:0] sr;
    logic [31:0] eff;
  } seg_a_t;

  typedef struct packed {
    logic        ring_ok;
    logic        trans_ok;
    logic        bucket_ok;
    logic [31:0] eff;
    logic [14:0] cn;
  } seg_c_t;

  typedef struct packed {
    logic [31:0] eff;
    logic [14:0] cn;
  } seg_d_t;

  typedef struct packed {
    logic [31:0] eff;
    logic [14:0] cn;
    logic [56:0] d1;
    logic [56:0] d2;
  } seg_f_t;

  typedef struct packed {
    logic [31:0] eff;
    logic [14:0] cn;
    logic [56:0] d1;
    logic [56:0] d2;
    logic [24:0] k;
  } seg_g_t;

  typedef struct packed {
    logic [14:0] cn;
    logic [56:0] d1;
    logic [56:0] d2;
    logic [24:0] k;
  } seg_h_t;

  typedef struct packed {
    logic [14:0] cn;
    logic [56:0] d2;
  } seg_j_t;

  typedef struct packed {
    logic [31:0] corrected_efficiency;
    logic [14:0] crystal_number;
    logic        saturated;
  } result_t;

  logic en;

  // Configuration registers.
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CRYSTALS_IN_RING:     cfg_r.crystals_in_ring     <= cfg_data[9:0];
        CFG_TRANSAXIAL_PER_BLOCK: cfg_r.transaxial_per_block <= cfg_data[3:0];
        CFG_AXIAL_PER_BLOCK:      cfg_r.axial_per_block      <= cfg_data[5:0];
        CFG_BLOCKS_IN_BUCKET:     cfg_r.blocks_in_bucket     <= cfg_data[3:0];
        CFG_CRYSTALS_IN_BUCKET:   cfg_r.crystals_in_bucket   <= cfg_data[6:0];
        CFG_BUCKETS_IN_RING:      cfg_r.buckets_in_ring      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic [6:0] den_cib;
  logic [6:0] den_apb;
  logic [6:0] den_tpb;
  logic [3:0] den_blk;

  assign den_cib = (cfg_r.crystals_in_bucket == '0) ? 7'd1 : cfg_r.crystals_in_bucket;
  assign den_apb = (cfg_r.axial_per_block == '0) ? 7'd1 : {1'b0, cfg_r.axial_per_block};
  assign den_tpb = (cfg_r.transaxial_per_block == '0) ? 7'd1 :
                   {3'd0, cfg_r.transaxial_per_block};
  assign den_blk = (cfg_r.blocks_in_bucket == '0) ? 4'd1 : cfg_r.blocks_in_bucket;

  // Input register.
  logic   s0_v_r;
  seg_a_t s0_r;

  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r     <= in_ch.valid;
      s0_r       <= '{action:      action_t'(in_ch.action),
                      idx:         in_ch.table_index,
                      ring:        in_ch.ring,
                      crystal:     in_ch.crystal,
                      pt:          in_ch.paralyzing_time,
                      nt:          in_ch.nonparalyzing_time,
                      sr:          in_ch.singles_rate,
                      eff:         in_ch.base_efficiency};
    end
  end

  // Bucket and transaxial position.
  logic                      a_v;
  logic [9:0]                q_cib;
  logic [9:0]                q_apb;
  logic [6:0]                rem_tpb;
  logic [$bits(seg_a_t)-1:0] a_side_vec;
  seg_a_t                    a_side;

  cde_div #(.NW(10), .DW(7), .QW(10), .SW($bits(seg_a_t))) u_div_cib (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(s0_v_r),
    .num(s0_r.crystal), .den(den_cib), .side_in(s0_r),
    .v_out(a_v), .quo(q_cib), .rem(), .side_out(a_side_vec)
  );

  cde_div #(.NW(10), .DW(7), .QW(10), .SW(1)) u_div_apb (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(s0_v_r),
    .num({5'd0, s0_r.ring}), .den(den_apb), .side_in(1'b0),
    .v_out(), .quo(q_apb), .rem(), .side_out()
  );

  cde_div #(.NW(10), .DW(7), .QW(10), .SW(1)) u_div_tpb (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(s0_v_r),
    .num(s0_r.crystal), .den(den_tpb), .side_in(1'b0),
    .v_out(), .quo(), .rem(rem_tpb), .side_out()
  );

  assign a_side = seg_a_t'(a_side_vec);

  logic [16:0] bucket;
  logic [16:0] idx_ext;
  logic [16:0] ring_ext;
  logic [16:0] trans_ext;
  logic        ring_ok;
  logic        trans_ok;
  logic        bucket_ok;
  logic [14:0] cn;
  logic        ld_ring;
  logic        ld_trans;
  logic        ld_bucket;

  assign bucket    = 17'(q_cib) + 17'(cfg_r.buckets_in_ring) * 17'(q_apb);
  assign idx_ext   = 17'(a_side.idx);
  assign ring_ext  = 17'(a_side.ring);
  assign trans_ext = 17'(rem_tpb);
  assign ring_ok   = int'(ring_ext) < MAX_RINGS;
  assign trans_ok  = int'(trans_ext) < MAX_BLOCK_WIDTH;
  assign bucket_ok = int'(bucket) < MAX_BUCKETS;
  assign cn        = 15'(15'(a_side.ring) * 15'(cfg_r.crystals_in_ring)
                     + 15'(a_side.crystal));

  assign ld_ring   = a_v && (a_side.action == ACT_LOAD_RING) &&
                     (int'(idx_ext) < MAX_RINGS);
  assign ld_trans  = a_v && (a_side.action == ACT_LOAD_TRANS) &&
                     (int'(idx_ext) < MAX_BLOCK_WIDTH);
  assign ld_bucket = a_v && (a_side.action == ACT_LOAD_BUCKET) &&
                     (int'(idx_ext) < MAX_BUCKETS);

  // Tables are written and read at the same pipeline position, so every
  // compute word sees exactly the loads that came before it.
  logic [31:0] ring_pt_mem [MAX_RINGS];
  logic [31:0] ring_nt_mem [MAX_RINGS];
  logic [31:0] trans_mem   [MAX_BLOCK_WIDTH];
  logic [31:0] bucket_mem  [MAX_BUCKETS];

  logic        c_v_r;
  seg_c_t      c_r;
  logic [31:0] c_pt_r;
  logic [31:0] c_nt_r;
  logic [31:0] c_tc_r;
  logic [31:0] c_sr_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (ld_ring) begin
        ring_pt_mem[idx_ext[RAW-1:0]] <= a_side.pt;
        ring_nt_mem[idx_ext[RAW-1:0]] <= a_side.nt;
      end
      c_pt_r <= ring_pt_mem[ring_ext[RAW-1:0]];
      c_nt_r <= ring_nt_mem[ring_ext[RAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ld_trans) begin
        trans_mem[idx_ext[TAW-1:0]] <= a_side.nt;
      end
      c_tc_r <= trans_mem[trans_ext[TAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ld_bucket) begin
        bucket_mem[idx_ext[BAW-1:0]] <= a_side.sr;
      end
      c_sr_r <= bucket_mem[bucket[BAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= a_v && (a_side.action == ACT_COMPUTE);
      c_r   <= '{ring_ok: ring_ok, trans_ok: trans_ok, bucket_ok: bucket_ok,
                 eff: a_side.eff, cn: cn};
    end
  end

  // Deadtime times singles.
  logic [31:0] ta;
  logic [31:0] tb;
  logic [31:0] tc;
  logic [31:0] sr;
  logic        d_v_r;
  seg_d_t      d_r;
  logic [63:0] d_xa_r;
  logic [63:0] d_xb_r;
  logic [63:0] d_xc_r;

  assign ta = c_r.ring_ok   ? c_pt_r : '0;
  assign tb = c_r.ring_ok   ? c_nt_r : '0;
  assign tc = c_r.trans_ok  ? c_tc_r : '0;
  assign sr = c_r.bucket_ok ? c_sr_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (en) begin
      d_v_r  <= c_v_r;
      d_r    <= '{eff: c_r.eff, cn: c_r.cn};
      d_xa_r <= {32'd0, ta} * {32'd0, sr};
      d_xb_r <= {32'd0, tb} * {32'd0, sr};
      d_xc_r <= {32'd0, tc} * {32'd0, sr};
    end
  end

  // Rates in Q32: product over 256 times the blocks in a bucket.
  logic                      r_v;
  logic [55:0]               ar;
  logic [55:0]               br;
  logic [55:0]               cr;
  logic [$bits(seg_d_t)-1:0] r_side_vec;

  cde_div #(.NW(56), .DW(4), .QW(56), .SW($bits(seg_d_t))) u_div_ar (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(d_v_r),
    .num(d_xa_r[63:8]), .den(den_blk), .side_in(d_r),
    .v_out(r_v), .quo(ar), .rem(), .side_out(r_side_vec)
  );

  cde_div #(.NW(56), .DW(4), .QW(56), .SW(1)) u_div_br (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(d_v_r),
    .num(d_xb_r[63:8]), .den(den_blk), .side_in(1'b0),
    .v_out(), .quo(br), .rem(), .side_out()
  );

  cde_div #(.NW(56), .DW(4), .QW(56), .SW(1)) u_div_cr (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(d_v_r),
    .num(d_xc_r[63:8]), .den(den_blk), .side_in(1'b0),
    .v_out(), .quo(cr), .rem(), .side_out()
  );

  logic        e_v_r;
  seg_f_t      e_r;
  logic [55:0] e_ar_r;
  seg_d_t      r_side;

  assign r_side = seg_d_t'(r_side_vec);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (en) begin
      e_v_r  <= r_v;
      e_ar_r <= ar;
      e_r    <= '{eff: r_side.eff, cn: r_side.cn,
                  d1: 57'h1_0000_0000 + 57'(br),
                  d2: 57'h1_0000_0000 + 57'(cr)};
    end
  end

  // Exponent argument and its split into k*ln2 + f.
  logic                      x_v;
  logic [55:0]               ex;
  logic [$bits(seg_f_t)-1:0] x_side_vec;

  cde_div #(.NW(88), .DW(57), .QW(56), .SW($bits(seg_f_t))) u_div_e (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(e_v_r),
    .num({e_ar_r, 32'd0}), .den(e_r.d1), .side_in(e_r),
    .v_out(x_v), .quo(ex), .rem(), .side_out(x_side_vec)
  );

  logic                      k_v;
  logic [24:0]               k_q;
  logic [31:0]               f_rem;
  seg_f_t                    k_side;
  seg_g_t                    g_in;

  // A reciprocal estimate of k is low by at most one, and one compare and
  // subtract settles it. An argument of 64*ln2 or more gives a zero result.
  localparam logic [55:0] LN2_X64   = 56'(64'(LN2_Q32) << 6);
  localparam logic [31:0] LN2_RECIP = 32'(64'h8000_0000_0000_0000 / 64'(LN2_Q32));

  logic        kx_v_r;
  logic        kx_big_r;
  logic [37:0] kx_e_r;
  seg_f_t      kx_r;
  logic [63:0] kx_prod;
  logic        ky_v_r;
  logic        ky_big_r;
  logic [37:0] ky_e_r;
  logic [5:0]  ky_k0_r;
  seg_f_t      ky_r;
  logic [37:0] ky_r0;
  logic        ky_up;
  logic [37:0] ky_f;
  logic        kz_v_r;
  logic [24:0] kz_k_r;
  logic [31:0] kz_f_r;
  seg_f_t      kz_r;

  assign kx_prod = {32'd0, kx_e_r[37:6]} * {32'd0, LN2_RECIP};
  assign ky_r0   = ky_e_r - 38'(ky_k0_r) * 38'(LN2_Q32);
  assign ky_up   = (ky_r0 >= 38'(LN2_Q32));
  assign ky_f    = ky_up ? (ky_r0 - 38'(LN2_Q32)) : ky_r0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kx_v_r <= 1'b0;
      ky_v_r <= 1'b0;
      kz_v_r <= 1'b0;
    end else if (en) begin
      kx_v_r   <= x_v;
      kx_big_r <= (ex >= LN2_X64);
      kx_e_r   <= ex[37:0];
      kx_r     <= seg_f_t'(x_side_vec);
      ky_v_r   <= kx_v_r;
      ky_big_r <= kx_big_r;
      ky_e_r   <= kx_e_r;
      ky_k0_r  <= kx_prod[62:57];
      ky_r     <= kx_r;
      kz_v_r   <= ky_v_r;
      kz_k_r   <= ky_big_r ? 25'd64 : 25'(ky_k0_r) + 25'(ky_up);
      kz_f_r   <= ky_big_r ? 32'd0 : ky_f[31:0];
      kz_r     <= ky_r;
    end
  end

  assign k_v    = kz_v_r;
  assign k_q    = kz_k_r;
  assign f_rem  = kz_f_r;
  assign k_side = kz_r;
  assign g_in   = '{eff: k_side.eff, cn: k_side.cn, d1: k_side.d1, d2: k_side.d2, k: k_q};

  logic                      g_v;
  logic [33:0]               s_exp;
  logic [$bits(seg_g_t)-1:0] g_side_vec;
  seg_g_t                    g_side;
  seg_h_t                    h_in;

  cde_exp #(.SW($bits(seg_g_t))) u_exp (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(k_v), .f_in(f_rem), .side_in(g_in),
    .v_out(g_v), .sum_out(s_exp), .side_out(g_side_vec)
  );

  assign g_side = seg_g_t'(g_side_vec);
  assign h_in   = '{cn: g_side.cn, d1: g_side.d1, d2: g_side.d2, k: g_side.k};

  // Efficiency divided by exp, then by both denominators.
  logic                      h_v;
  logic [31:0]               y1;
  logic [$bits(seg_h_t)-1:0] h_side_vec;
  seg_h_t                    h_side;

  cde_div #(.NW(64), .DW(34), .QW(32), .SW($bits(seg_h_t))) u_div_y1 (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(g_v),
    .num({g_side.eff, 32'd0}), .den(s_exp), .side_in(h_in),
    .v_out(h_v), .quo(y1), .rem(), .side_out(h_side_vec)
  );

  assign h_side = seg_h_t'(h_side_vec);

  logic        i_v_r;
  logic [31:0] i_y_r;
  seg_h_t      i_r;
  seg_j_t      j_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_v_r <= 1'b0;
    end else if (en) begin
      i_v_r <= h_v;
      i_y_r <= (h_side.k < 25'd64) ? (y1 >> h_side.k[5:0]) : '0;
      i_r   <= h_side;
    end
  end

  assign j_in = '{cn: i_r.cn, d2: i_r.d2};

  logic                      j_v;
  logic [31:0]               y3;
  logic [$bits(seg_j_t)-1:0] j_side_vec;
  seg_j_t                    j_side;

  cde_div #(.NW(64), .DW(57), .QW(32), .SW($bits(seg_j_t))) u_div_y3 (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(i_v_r),
    .num({i_y_r, 32'd0}), .den(i_r.d1), .side_in(j_in),
    .v_out(j_v), .quo(y3), .rem(), .side_out(j_side_vec)
  );

  assign j_side = seg_j_t'(j_side_vec);

  logic        p_v;
  logic [31:0] y4;
  logic [14:0] p_cn;

  cde_div #(.NW(64), .DW(57), .QW(32), .SW(15)) u_div_y4 (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(j_v),
    .num({y3, 32'd0}), .den(j_side.d2), .side_in(j_side.cn),
    .v_out(p_v), .quo(y4), .rem(), .side_out(p_cn)
  );

  // Every factor is at most one, so the quotient always fits and the
  // saturation flag stays clear.
  result_t p_res;
  logic    p_take;

  assign p_res  = '{corrected_efficiency: y4, crystal_number: p_cn, saturated: 1'b0};
  assign p_take = en && p_v;

  // Output register with skid.
  logic    out_v_r;
  result_t out_r;
  logic    skid_v_r;
  result_t skid_r;

  assign en = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        out_r    <= skid_r;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= p_take;
        out_r   <= p_res;
      end
    end else if (p_take) begin
      skid_v_r <= 1'b1;
      skid_r   <= p_res;
    end
  end

  assign out_ch.valid                = out_v_r;
  assign out_ch.corrected_efficiency = out_r.corrected_efficiency;
  assign out_ch.crystal_number       = out_r.crystal_number;
  assign out_ch.saturated            = out_r.saturated;

endmodule

FILE: hw/rtl/cde_chk.sv
// ----------------------------------------------------------------------------
// Crystal deadtime efficiency checker
// Port-level checks on the result channel and the input back-pressure.
// ----------------------------------------------------------------------------
module cde_chk import cde_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] corrected_efficiency,
  input logic        saturated
);

  // A result word that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(corrected_efficiency))
    else $error("result word changed while stalled");

  // The result never exceeds the base efficiency, so it is never clipped.
  a_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !saturated)
    else $error("saturated flag set");

  // Input back-pressure only while a result word waits.
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled without a waiting result");

  // The input only stalls after a refused result word.
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input stalled without a refused result");

  // No result directly after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word after reset");

endmodule

bind crystal_deadtime_efficiency cde_chk u_cde_chk (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_ready             (in_ch.ready),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .corrected_efficiency (out_ch.corrected_efficiency),
  .saturated            (out_ch.saturated)
);

FILE: test/tb_crystal_deadtime_efficiency.sv
// ----------------------------------------------------------------------------
// Crystal deadtime efficiency testbench
// Loads the deadtime and singles tables, then sends compute and load words
// under several register settings. A scoreboard predicts every result in
// fixed point and checks the results in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_crystal_deadtime_efficiency;
  import cde_pkg::*;

  localparam int NUM_RINGS  = MAX_RINGS_DEF;
  localparam int NUM_TRANS  = MAX_BLOCK_WIDTH_DEF;
  localparam int NUM_BUCKET = MAX_BUCKETS_DEF;
  localparam int DRAIN      = 320;
  localparam int STALL_LIMIT = 6000;

  typedef struct {
    logic [31:0] efficiency;
    logic [14:0] crystal_number;
    logic        saturated;
  } eff_result_t;

  class eff_scoreboard;
    cfg_t        regs;
    logic [31:0] ring_par [NUM_RINGS];
    logic [31:0] ring_nonpar [NUM_RINGS];
    logic [31:0] trans_nonpar [NUM_TRANS];
    logic [31:0] singles [NUM_BUCKET];
    eff_result_t pending [$];
    int          errors;

    function new();
      regs = CFG_RESET;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [9:0] v);
      case (idx)
        CFG_CRYSTALS_IN_RING:     regs.crystals_in_ring = v;
        CFG_TRANSAXIAL_PER_BLOCK: regs.transaxial_per_block = v[3:0];
        CFG_AXIAL_PER_BLOCK:      regs.axial_per_block = v[5:0];
        CFG_BLOCKS_IN_BUCKET:     regs.blocks_in_bucket = v[3:0];
        CFG_CRYSTALS_IN_BUCKET:   regs.crystals_in_bucket = v[6:0];
        CFG_BUCKETS_IN_RING:      regs.buckets_in_ring = v[6:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] scaled_quotient(logic [63:0] num, logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      q = num / den;
      r = num % den;
      for (int i = 0; i < 32; i++) begin
        if (q[63]) return 64'hFFFF_FFFF_FFFF_FFFF;
        q = q << 1;
        if (r >= den - r) begin
          r = r - (den - r);
          q[0] = 1'b1;
        end else begin
          r = r << 1;
        end
      end
      return q;
    endfunction

    function logic [63:0] at_least_one(logic [63:0] v);
      return (v == 0) ? 64'd1 : v;
    endfunction

    function void note_word(action_t act, logic [5:0] idx, logic [4:0] ring,
                            logic [9:0] crystal, logic [31:0] par,
                            logic [31:0] nonpar, logic [31:0] rate,
                            logic [31:0] eff);
      logic [63:0] bucket, trans, s, ta, tb, tc, dv, ar, br, cr, d1, d2;
      logic [63:0] e, k, f, term, sum, y;
      eff_result_t res;
      case (act)
        ACT_LOAD_RING: begin
          if (idx < NUM_RINGS) begin
            ring_par[idx[4:0]] = par;
            ring_nonpar[idx[4:0]] = nonpar;
          end
        end
        ACT_LOAD_TRANS: begin
          if (idx < NUM_TRANS) trans_nonpar[idx[2:0]] = nonpar;
        end
        ACT_LOAD_BUCKET: begin
          if (idx < NUM_BUCKET) singles[idx] = rate;
        end
        default: begin
          bucket = 64'(crystal) / at_least_one(64'(regs.crystals_in_bucket))
                 + 64'(regs.buckets_in_ring)
                   * (64'(ring) / at_least_one(64'(regs.axial_per_block)));
          trans = 64'(crystal) % at_least_one(64'(regs.transaxial_per_block));
          s  = (bucket < NUM_BUCKET) ? 64'(singles[bucket[5:0]]) : 64'd0;
          ta = (ring < NUM_RINGS) ? 64'(ring_par[ring]) : 64'd0;
          tb = (ring < NUM_RINGS) ? 64'(ring_nonpar[ring]) : 64'd0;
          tc = (trans < NUM_TRANS) ? 64'(trans_nonpar[trans[2:0]]) : 64'd0;
          dv = at_least_one(64'(regs.blocks_in_bucket)) << 8;
          ar = (ta * s) / dv;
          br = (tb * s) / dv;
          cr = (tc * s) / dv;
          d1 = 64'h1_0000_0000 + br;
          d2 = 64'h1_0000_0000 + cr;
          e = scaled_quotient(ar, d1);
          k = e / 64'(LN2_Q32);
          f = e - k * 64'(LN2_Q32);
          sum = 64'h1_0000_0000;
          term = 64'h1_0000_0000;
          for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            term = ((term * f) >> 32) / 64'(n);
            sum = sum + term;
          end
          y = scaled_quotient(64'(eff), sum);
          y = (k < 64) ? (y >> k) : 64'd0;
          y = scaled_quotient(y, d1);
          y = scaled_quotient(y, d2);
          res.saturated = (y > 64'hFFFF_FFFF);
          res.efficiency = res.saturated ? 32'hFFFF_FFFF : y[31:0];
          res.crystal_number = 15'(32'(ring) * 32'(regs.crystals_in_ring)
                                   + 32'(crystal));
          pending.push_back(res);
        end
      endcase
    endfunction

    function void check_result(logic [31:0] eff, logic [14:0] num, logic sat);
      eff_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result eff=%h number=%0d sat=%b",
                 $time, eff, num, sat);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (eff !== want.efficiency) begin
        $display("%0t: efficiency expected %h actual %h", $time,
                 want.efficiency, eff);
        errors++;
      end
      if (num !== want.crystal_number) begin
        $display("%0t: crystal number expected %0d actual %0d", $time,
                 want.crystal_number, num);
        errors++;
      end
      if (sat !== want.saturated) begin
        $display("%0t: saturated expected %b actual %b", $time,
                 want.saturated, sat);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [9:0] cfg_data;
  bit         idling;
  int         quiet_cycles;
  int         out_hold;

  cde_in_if  in_ch();
  cde_out_if out_ch();

  eff_scoreboard sb;

  crystal_deadtime_efficiency uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.corrected_efficiency, out_ch.crystal_number,
                      out_ch.saturated);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (!in_ch.valid && sb.pending.size() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result side stalls in bursts while idling is on.
  always @(negedge clk) begin
    if (!idling) begin
      out_ch.ready <= 1'b1;
      out_hold <= 0;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      if (out_hold == 1) out_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      out_hold <= $urandom_range(1, 15);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 255);
      3, 4: return $urandom();
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic send_word(action_t act, logic [5:0] idx, logic [4:0] ring,
                           logic [9:0] crystal, logic [31:0] par,
                           logic [31:0] nonpar, logic [31:0] rate,
                           logic [31:0] eff);
    @(negedge clk);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.action = act;
    in_ch.table_index = idx;
    in_ch.ring = ring;
    in_ch.crystal = crystal;
    in_ch.paralyzing_time = par;
    in_ch.nonparalyzing_time = nonpar;
    in_ch.singles_rate = rate;
    in_ch.base_efficiency = eff;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(act, idx, ring, crystal, par, nonpar, rate, eff);
  endtask

  task automatic send_compute(logic [4:0] ring, logic [9:0] crystal,
                              logic [31:0] eff);
    send_word(ACT_COMPUTE, 6'($urandom()), ring, crystal, $urandom(), $urandom(),
              $urandom(), eff);
  endtask

  task automatic fill_tables();
    for (int i = 0; i < NUM_RINGS; i++)
      send_word(ACT_LOAD_RING, 6'(i), 5'($urandom()), 10'($urandom()), pick_value(),
                pick_value(), $urandom(), $urandom());
    for (int i = 0; i < NUM_TRANS; i++)
      send_word(ACT_LOAD_TRANS, 6'(i), 5'($urandom()), 10'($urandom()), $urandom(),
                pick_value(), $urandom(), $urandom());
    for (int i = 0; i < NUM_BUCKET; i++)
      send_word(ACT_LOAD_BUCKET, 6'(i), 5'($urandom()), 10'($urandom()), $urandom(),
                $urandom(), pick_value(), $urandom());
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_regs(logic [9:0] cir, logic [9:0] tpb, logic [9:0] apb,
                            logic [9:0] bib, logic [9:0] cib, logic [9:0] bir);
    logic [9:0] vals [6];
    vals = '{cir, tpb, apb, bib, cib, bir};
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_we = 1'b1;
      cfg_index = i[2:0];
      cfg_data = vals[i];
      sb.set_reg(cfg_reg_t'(i), vals[i]);
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_words(int count);
    logic [9:0] crystal;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0: send_word(ACT_LOAD_RING, 6'($urandom()), 5'($urandom()), 10'($urandom()),
                     pick_value(), pick_value(), $urandom(), $urandom());
        1: send_word(ACT_LOAD_TRANS, 6'($urandom()), 5'($urandom()), 10'($urandom()),
                     $urandom(), pick_value(), $urandom(), $urandom());
        2: send_word(ACT_LOAD_BUCKET, 6'($urandom()), 5'($urandom()), 10'($urandom()),
                     $urandom(), $urandom(), pick_value(), $urandom());
        default: begin
          if ($urandom_range(0, 3) == 0 || sb.regs.crystals_in_ring == 0)
            crystal = 10'($urandom());
          else
            crystal = 10'($urandom_range(0, sb.regs.crystals_in_ring - 1));
          send_compute(5'($urandom()), crystal, pick_value());
        end
      endcase
    end
  endtask

  initial begin
    sb = new();
    idling = 1'b0;
    quiet_cycles = 0;
    out_hold = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_LOAD_RING;
    in_ch.table_index = '0;
    in_ch.ring = '0;
    in_ch.crystal = '0;
    in_ch.paralyzing_time = '0;
    in_ch.nonparalyzing_time = '0;
    in_ch.singles_rate = '0;
    in_ch.base_efficiency = '0;
    out_ch.ready = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    fill_tables();
    // Directed words: ignored loads, zero and full deadtimes, field extremes.
    send_word(ACT_LOAD_RING, 6'd63, '1, '1, '1, '1, '1, '1);
    send_word(ACT_LOAD_TRANS, 6'd8, '1, '1, '1, '1, '1, '1);
    send_word(ACT_LOAD_BUCKET, 6'd63, '1, '1, '1, '1, 32'hFFFF_FFFF, '1);
    send_word(ACT_LOAD_RING, 6'd0, '0, '0, '0, '0, '0, '0);
    send_word(ACT_LOAD_RING, 6'd31, '0, '0, '1, '1, '0, '0);
    send_word(ACT_LOAD_TRANS, 6'd7, '0, '0, '0, '1, '0, '0);
    send_word(ACT_LOAD_BUCKET, 6'd0, '0, '0, '0, '0, 32'd1000000, '0);
    send_compute(5'd0, 10'd0, 32'h4000_0000);
    send_compute(5'd0, 10'd1, 32'hFFFF_FFFF);
    send_compute(5'd0, 10'd2, 32'd0);
    send_compute(5'd31, 10'd1023, 32'hFFFF_FFFF);
    send_compute(5'd31, 10'd383, 32'h4000_0000);
    send_compute(5'd31, 10'd7, 32'h4000_0000);
    send_compute(5'd7, 10'd1000, 32'h3FFF_FFFF);
    send_compute(5'd15, 10'd512, 32'h8000_0000);
    wait_drained();

    idling = 1'b1;
    random_words(150);
    wait_drained();

    write_regs(10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
    random_words(250);
    wait_drained();

    write_regs(10'd1023, 10'd8, 10'd32, 10'd15, 10'd120, 10'd64);
    fill_tables();
    random_words(200);
    wait_drained();

    write_regs(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
    random_words(200);
    wait_drained();

    write_regs(10'h3FF, 10'hF, 10'h3F, 10'hF, 10'h7F, 10'h7F);
    random_words(200);
    wait_drained();

    write_regs(10'($urandom_range(1, 1023)), 10'($urandom_range(1, 8)),
               10'($urandom_range(1, 32)), 10'($urandom_range(1, 15)),
               10'($urandom_range(1, 120)), 10'($urandom_range(1, 64)));
    fill_tables();
    random_words(200);
    wait_drained();

    idling = 1'b0;
    write_regs(10'd384, 10'd8, 10'd8, 10'd3, 10'd24, 10'd16);
    random_words(200);
    wait_drained();

    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
